FILE: hw/rtl/lphs_pkg.sv
`default_nettype none

package lphs_pkg;

    // Field and register widths
    localparam int KEY_W      = 31;
    localparam int ACTION_W   = 2;
    localparam int CFG_W      = 5;
    localparam int STATUS_W   = 2;

    // Port widths
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Default slot store depth and reset value of the slot count register
    localparam int                SLOTS_DEFAULT = 16;
    localparam logic [CFG_W-1:0]  SLOTS_RESET   = 5'd16;

    // Register index (taken from the word address bit)
    localparam logic REG_SLOTS_IN_USE = 1'b0;

    // Request codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    // Slot status codes
    localparam logic [STATUS_W-1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [STATUS_W-1:0] SLOT_LIVE    = 2'd1;
    localparam logic [STATUS_W-1:0] SLOT_DELETED = 2'd2;

    // Remainder unit: key bits consumed per cycle
    localparam int MOD_BITS   = 4;
    localparam int MOD_CYCLES = (KEY_W + MOD_BITS - 1) / MOD_BITS;
    localparam int MOD_PAD_W  = MOD_CYCLES * MOD_BITS;
    localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    typedef struct packed {
        logic               start;
        logic [KEY_W-1:0]   key;
        logic [CFG_W-1:0]   modulus;
    } mod_req_t;

    typedef struct packed {
        logic               done;
        logic [CFG_W-1:0]   rem;
    } mod_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lphs_ram.sv
`default_nettype none

module lphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lphs_mod.sv
`default_nettype none

module lphs_mod
    import lphs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mod_req_t req,
    output mod_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_PAD_W-1:0] shift_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W-1:0]     rem_next;
    logic [CFG_W-1:0]     mod_reg;

    // Restoring remainder, MOD_BITS key bits per cycle, most significant first
    always_comb
    begin
        logic [CFG_W-1:0] r;
        logic [CFG_W:0]   t;
        r = rem_reg;
        t = '0;
        for (int k = 0; k < MOD_BITS; k++)
        begin
            t = {r, shift_reg[MOD_PAD_W-1-k]};
            if (t >= {1'b0, mod_reg})
            begin
                t = t - {1'b0, mod_reg};
            end
            r = t[CFG_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            shift_reg <= MOD_PAD_W'(req.key);
            rem_reg   <= '0;
            mod_reg   <= req.modulus;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << MOD_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/linear_probe_hash_set_top.sv
// Flow: each accepted request runs the 4-bit-per-cycle key modulo, then k probe steps (1 to the
//   clamped slot count), one slot store read each through the single read port; requests that need
//   no probe (full table on insert, empty set, unused action) skip the probe steps.
// Requests: one at a time, the next only once the last result is in the output register.
// Reset: asynchronous, active low; slot count returns to 16, live count to 0, and a clearing
//   pass empties every slot of the slot store; it repeats after every slot count write.
`default_nettype none

module linear_probe_hash_set_top
    import lphs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Request stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [1:0] action, [32:2] key, rest zero
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // [0] success, rest zero
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int               IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int               SLOT_CAP = (SLOTS < 31) ? SLOTS : 31;
    localparam logic [CFG_W-1:0] CAP_N    = CFG_W'(SLOT_CAP);
    localparam int               RAM_W    = STATUS_W + KEY_W;

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MOD   = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [CFG_W-1:0]    slots_reg;
    logic [CFG_W-1:0]    n_active;
    logic                cfg_wr;

    logic                clr_busy_reg;
    logic [IDX_W-1:0]    clr_idx_reg;

    logic [1:0]          state_reg,  state_next;
    logic [ACTION_W-1:0] action_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [CFG_W-1:0]    idx_reg,    idx_next;
    logic [CFG_W-1:0]    home_reg,   home_next;
    logic [CFG_W-1:0]    step_reg,   step_next;
    logic [CFG_W-1:0]    live_reg,   live_next;
    logic                ok_reg,     ok_next;
    logic                out_valid_reg;
    logic                out_success_reg;

    logic                s_accept;
    logic                out_load;
    logic [CFG_W-1:0]    idx_inc;
    logic [CFG_W-1:0]    rd_idx;

    logic                fsm_we;
    logic [RAM_W-1:0]    fsm_wdata;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [RAM_W-1:0]    ram_rdata;
    logic [STATUS_W-1:0] rd_status;
    logic [KEY_W-1:0]    rd_key;
    logic                rd_live;
    logic                rd_empty;
    logic                rd_hit;

    mod_req_t            mod_req;
    mod_rsp_t            mod_rsp;

    // ------------------------------------------------------------------
    // Configuration: one register, slot count. A write restarts the clear.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1] == REG_SLOTS_IN_USE);
    assign prdata = (paddr[APB_ADDR_W-1] == REG_SLOTS_IN_USE)
                    ? APB_DATA_W'(slots_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_RESET;
        end
        else if (cfg_wr)
        begin
            slots_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Clamp the modulus: zero acts as one, anything above the store depth (capped at 31) as that cap
    always_comb
    begin
        priority if (slots_reg == '0)
        begin
            n_active = CFG_W'(1);
        end
        else if (slots_reg > CAP_N)
        begin
            n_active = CAP_N;
        end
        else
        begin
            n_active = slots_reg;
        end
    end

    // Clearing pass: write every slot empty, one per cycle; requests wait
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(SLOTS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Key modulo unit
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE) && !clr_busy_reg;
    assign s_accept = s_tvalid && s_tready;

    assign mod_req.start   = s_accept;
    assign mod_req.key     = s_tdata[ACTION_W +: KEY_W];
    assign mod_req.modulus = n_active;

    lphs_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // ------------------------------------------------------------------
    // Slot store: {status, key} per entry, one write and one read per cycle
    // ------------------------------------------------------------------
    assign rd_status = ram_rdata[RAM_W-1:KEY_W];
    assign rd_key    = ram_rdata[KEY_W-1:0];
    assign rd_live   = (rd_status == SLOT_LIVE);
    assign rd_empty  = (rd_status == SLOT_EMPTY);
    assign rd_hit    = (rd_key == key_reg);

    assign ram_we    = clr_busy_reg || fsm_we;
    assign ram_waddr = clr_busy_reg ? clr_idx_reg : IDX_W'(idx_reg);
    assign ram_wdata = clr_busy_reg ? {SLOT_EMPTY, {KEY_W{1'b0}}} : fsm_wdata;

    lphs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (IDX_W'(rd_idx)),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Probe sequencer. In S_PROBE the read data belongs to idx_reg; when the
    // probe goes on, the next slot's read is issued in the same cycle.
    // The only write ends the request, so no read can overlap it.
    // ------------------------------------------------------------------
    assign idx_inc  = ((idx_reg + 1'b1) == n_active) ? '0 : idx_reg + 1'b1;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        home_next  = home_reg;
        step_next  = step_reg;
        live_next  = live_reg;
        ok_next    = ok_reg;
        rd_idx     = idx_reg;
        fsm_we     = 1'b0;
        fsm_wdata  = {SLOT_LIVE, key_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    ok_next    = 1'b0;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    rd_idx    = mod_rsp.rem;
                    idx_next  = mod_rsp.rem;
                    home_next = mod_rsp.rem;
                    step_next = CFG_W'(1);
                    // Full table on insert, empty set on search or delete,
                    // or an unused action: answer without probing
                    if ((action_reg == ACT_INSERT && live_reg < n_active)
                        || ((action_reg == ACT_SEARCH || action_reg == ACT_DELETE)
                            && live_reg != '0))
                    begin
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PROBE:
            begin
                if (action_reg == ACT_INSERT)
                begin
                    priority if (!rd_live)
                    begin
                        fsm_we     = 1'b1;
                        fsm_wdata  = {SLOT_LIVE, key_reg};
                        live_next  = live_reg + 1'b1;
                        ok_next    = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (rd_hit || step_reg == n_active)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next  = idx_inc;
                        rd_idx    = idx_inc;
                        step_next = step_reg + 1'b1;
                    end
                end
                else
                begin
                    priority if (rd_empty)
                    begin
                        state_next = S_DONE;
                    end
                    else if (rd_live && rd_hit)
                    begin
                        ok_next    = 1'b1;
                        state_next = S_DONE;
                        if (action_reg == ACT_DELETE)
                        begin
                            fsm_we    = 1'b1;
                            fsm_wdata = {SLOT_DELETED, key_reg};
                            live_next = live_reg - 1'b1;
                        end
                    end
                    else if (idx_inc == home_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next  = idx_inc;
                        rd_idx    = idx_inc;
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // A slot count write empties the set
            live_reg  <= cfg_wr ? '0 : live_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold the request and probe position, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            action_reg <= s_tdata[ACTION_W-1:0];
            key_reg    <= s_tdata[ACTION_W +: KEY_W];
        end
        idx_reg  <= idx_next;
        home_reg <= home_next;
        step_reg <= step_next;
        ok_reg   <= ok_next;
        if (out_load)
        begin
            out_success_reg <= ok_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_success_reg);

`ifndef SYNTHESIS
    a_live_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= n_active)
        else $error("live count exceeds active slot count");

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_we |-> !clr_busy_reg)
        else $error("slot write from sequencer during clearing pass");

    a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (state_reg == S_MOD))
        else $error("modulo result outside modulo wait");

    a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (step_reg != '0 && step_reg <= n_active))
        else $error("probe ran past the slot count");

    a_live_change: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg != $past(live_reg) && !$past(cfg_wr)) |-> $past(fsm_we))
        else $error("live count moved without a slot write");
`endif

endmodule

`default_nettype wire
